>>> rtl/descending_exchange_sort_core_defines.svh
// Assertion macros for the sort core RTL, used by the controller.
// In synthesis the macros expand to nothing.
`ifndef DESCENDING_EXCHANGE_SORT_CORE_DEFINES_SVH
`define DESCENDING_EXCHANGE_SORT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define DESX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sort core assertion failed");

// The condition must never be seen outside reset.
`define DESX_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sort core forbidden condition seen");

`else

`define DESX_ASSERT(lbl, clk, rst_n, prop)
`define DESX_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/desx_pkg.sv
package desx_pkg;

    // Capacity of the record memory.
    localparam int MAX_RECORDS = 16;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    // Field widths.
    localparam int KEY_W  = 16;
    localparam int TAG_W  = 32;
    localparam int RANK_W = 7;

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_W  = ((KEY_W + TAG_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((KEY_W + TAG_W + RANK_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - KEY_W - TAG_W - RANK_W;

    // One record as held in memory; the key sits in the low bits.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } t_record;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_LDI,
        ST_LDW,
        ST_SCAN,
        ST_WRI,
        ST_EMIT
    } t_state;

    // Side information that travels with a memory read towards the output register.
    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic              last_w;
        logic              ovf;
    } t_emit_tag;

endpackage

>>> rtl/desx_rec_ram.sv
module desx_rec_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/desx_ctrl.sv
`include "descending_exchange_sort_core_defines.svh"

module desx_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Load side
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  desx_pkg::t_record            i_rec,
    input  logic                         i_s_tlast,
    // Record memory
    output logic                         o_we,
    output logic [desx_pkg::ADDR_W-1:0]  o_waddr,
    output desx_pkg::t_record            o_wdata,
    output logic                         o_re,
    output logic [desx_pkg::ADDR_W-1:0]  o_raddr,
    input  desx_pkg::t_record            i_rdata,
    // Output register status
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    output desx_pkg::t_emit_tag          o_emit
);

    import desx_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_drop, n_drop;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_e, n_e;
    logic              r_cmp_v, n_cmp_v;
    logic [ADDR_W-1:0] r_cmp_j, n_cmp_j;
    t_record           r_cur, n_cur;
    t_emit_tag         r_emit, n_emit;
    logic [CNT_W-1:0]  cnt_after;
    logic [CNT_W-1:0]  e_next;
    logic              issue;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_e     <= '0;
            r_cmp_v <= 1'b0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_i     <= n_i;
            r_j     <= n_j;
            r_e     <= n_e;
            r_cmp_v <= n_cmp_v;
            r_emit  <= n_emit;
        end
    end

    // Payload registers: the running maximum of a pass and the compared address.
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_cmp_j <= n_cmp_j;
    end

    // Next state, memory accesses and emission requests.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_i      = r_i;
        n_j      = r_j;
        n_e      = r_e;
        n_cmp_v  = r_cmp_v;
        n_cmp_j  = r_cmp_j;
        n_cur    = r_cur;
        n_emit   = '0;
        o_s_tready = 1'b0;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = r_cur;
        o_re     = 1'b0;
        o_raddr  = '0;
        cnt_after = (r_cnt < CNT_W'(MAX_RECORDS)) ? CNT_W'(r_cnt + CNT_W'(1)) : r_cnt;
        e_next    = CNT_W'(r_e + CNT_W'(1));
        issue     = 1'b0;

        case (r_state)
            // Store each word until the one marked last; full memory drops words.
            ST_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (r_cnt < CNT_W'(MAX_RECORDS)) begin
                        o_we    = 1'b1;
                        o_waddr = r_cnt[ADDR_W-1:0];
                        o_wdata = i_rec;
                        n_cnt   = cnt_after;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_i = '0;
                        n_e = '0;
                        if (cnt_after >= CNT_W'(2)) begin
                            n_state = ST_LDI;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end

            // Fetch record i, which a pass keeps in a register.
            ST_LDI: begin
                o_re    = 1'b1;
                o_raddr = r_i[ADDR_W-1:0];
                n_j     = CNT_W'(r_i + CNT_W'(1));
                n_state = ST_LDW;
            end

            ST_LDW: begin
                n_cur   = i_rdata;
                n_cmp_v = 1'b0;
                n_state = ST_SCAN;
            end

            // Read j each cycle; in the cycle after, compare and swap into address j.
            ST_SCAN: begin
                if (r_cmp_v && (r_cur.key < i_rdata.key)) begin
                    o_we    = 1'b1;
                    o_waddr = r_cmp_j;
                    o_wdata = r_cur;
                    n_cur   = i_rdata;
                end
                if (r_j < r_cnt) begin
                    o_re    = 1'b1;
                    o_raddr = r_j[ADDR_W-1:0];
                    n_cmp_v = 1'b1;
                    n_cmp_j = r_j[ADDR_W-1:0];
                    n_j     = CNT_W'(r_j + CNT_W'(1));
                end else begin
                    n_cmp_v = 1'b0;
                    if (!r_cmp_v) begin
                        n_state = ST_WRI;
                    end
                end
            end

            // Write the pass winner back to position i.
            ST_WRI: begin
                o_we    = 1'b1;
                o_waddr = r_i[ADDR_W-1:0];
                o_wdata = r_cur;
                n_i     = CNT_W'(r_i + CNT_W'(1));
                if (({1'b0, r_i} + (CNT_W+1)'(2)) >= {1'b0, r_cnt}) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_LDI;
                end
            end

            // Read one record when the output register will be free to take it.
            ST_EMIT: begin
                issue = !r_emit.valid && (!i_out_valid || i_out_ready);
                if (issue) begin
                    o_re          = 1'b1;
                    o_raddr       = r_e[ADDR_W-1:0];
                    n_emit.valid  = 1'b1;
                    n_emit.rank   = RANK_W'(e_next);
                    n_emit.last_w = (e_next == r_cnt);
                    n_emit.ovf    = r_drop;
                    n_e           = e_next;
                    if (e_next == r_cnt) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end

            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_emit = r_emit;

    // A swap during a pass only ever writes above position i.
    `DESX_ASSERT(a_swap_above_i, i_clk, i_rst_n, (r_state == ST_SCAN && o_we) |-> (CNT_W'(o_waddr) > r_i))
    // The fill count never passes the capacity.
    `DESX_ASSERT_NEVER(a_cnt_cap, i_clk, i_rst_n, r_cnt > CNT_W'(MAX_RECORDS))
    // While sorting, position i leaves at least one record above it.
    `DESX_ASSERT(a_sort_idx, i_clk, i_rst_n, (r_state == ST_LDI || r_state == ST_LDW || r_state == ST_SCAN || r_state == ST_WRI) |-> ((r_i + CNT_W'(1)) < r_cnt))
    // Read data for the output always lands in an empty output register.
    `DESX_ASSERT(a_land_free, i_clk, i_rst_n, r_emit.valid |-> !i_out_valid)

endmodule

>>> rtl/desx_out.sv
module desx_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  desx_pkg::t_emit_tag              i_emit,
    input  desx_pkg::t_record                i_rdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [desx_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tlast,
    output logic                             o_m_tuser
);

    import desx_pkg::*;

    logic              r_valid;
    t_record           r_rec;
    logic [RANK_W-1:0] r_rank;
    logic              r_last;
    logic              r_ovf;

    // Valid flag: set when a read lands, cleared when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.valid) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_emit.valid) begin
            r_rec  <= i_rdata;
            r_rank <= i_emit.rank;
            r_last <= i_emit.last_w;
            r_ovf  <= i_emit.ovf;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_rank, r_rec.tag, r_rec.key};
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_ovf;

endmodule

>>> rtl/descending_exchange_sort_core.sv
// Descending exchange sort core. Records (16-bit score key, 32-bit tag) stream in one per
// cycle and are stored in a 16-entry record memory; further records of a set are dropped.
// The word marked tlast ends the set and starts an in-place exchange sort into descending
// key order, tied keys ordered exactly as the classic i/j swap procedure leaves them. The
// sort runs through the memory's single read port: pass i keeps record i in a register,
// scans the records above it and writes the winner of the pass back to position i.
// The records then leave in rank order, each read only after the last one has reached the
// output register, carrying rank (1 for the highest key), tlast on the final word and
// tuser set on every word of a set that lost records. Input is held off during the sort
// and the emission; the next set may start loading while the last sorted word still
// waits at the output. No memory clearing is needed after reset.
module descending_exchange_sort_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // Fields from bit 0 up: score_key[15:0], record_tag[47:16].
    input  logic [desx_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // last_item.
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // Fields from bit 0 up: sorted_key[15:0], sorted_tag[47:16], rank_position[54:48], zero.
    output logic [desx_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // final_result.
    output logic                             o_m_tlast,
    // Field: overflow_flag[0].
    output logic                             o_m_tuser
);

    import desx_pkg::*;

    t_record           in_rec;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_record           wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    t_record           rdata;
    t_emit_tag         emit;

    // Unpack the input word.
    assign in_rec.key = i_s_tdata[KEY_W-1:0];
    assign in_rec.tag = i_s_tdata[KEY_W+TAG_W-1:KEY_W];

    // Sequencer for loading, sorting and emission.
    desx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_rec       (in_rec),
        .i_s_tlast   (i_s_tlast),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .i_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_emit      (emit)
    );

    // Record memory.
    desx_rec_ram #(
        .DEPTH (MAX_RECORDS),
        .WIDTH ($bits(t_record))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output register.
    desx_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_emit     (emit),
        .i_rdata    (rdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> sim/tb_descending_exchange_sort_core.sv
module tb_descending_exchange_sort_core;
    import desx_pkg::*;

    // One record as offered on the input stream.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_rec_word;

    // One ranked word as the block should emit it.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
        logic              fin;
        logic              ovf;
    } t_ranked_word;

    // Ways in which the receiver holds off.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_SPARSE
    } t_rx_mode;

    // Ways in which the keys of a random set are chosen.
    typedef enum logic [1:0] {
        KEYS_WIDE,
        KEYS_TIED,
        KEYS_EDGES,
        KEYS_RISING
    } t_key_style;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    // Stimulus and the word currently on offer.
    t_rec_word    pending_q[$];
    t_rec_word    offer;
    bit           offer_taken;
    int           total_records;

    // Expected ranked words, oldest first.
    t_ranked_word ranked_q[$];

    // Private copy of the block's record store.
    logic [KEY_W-1:0] store_key[MAX_RECORDS];
    logic [TAG_W-1:0] store_tag[MAX_RECORDS];
    int               fill_count;
    bit               lost_mark;

    int       accepted_count;
    int       words_checked;
    int       sets_sorted;
    int       sets_overflowed;
    int       fail_count;
    bit       stim_go;
    bit       rx_hold;
    int       burst_left = 1;
    int       gap_left;
    int       rx_phase_left;
    int       rx_tick;
    t_rx_mode rx_mode = RX_OPEN;

    descending_exchange_sort_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Store one accepted record; on the last one, sort and queue the ranked words.
    task automatic absorb_record(input t_rec_word rec);
        t_ranked_word     w;
        logic [KEY_W-1:0] tk;
        logic [TAG_W-1:0] tt;
        if (fill_count < MAX_RECORDS) begin
            store_key[fill_count] = rec.key;
            store_tag[fill_count] = rec.tag;
            fill_count++;
        end else begin
            lost_mark = 1'b1;
        end
        if (rec.last) begin
            // Exchange sort exactly as specified, so ties land where it leaves them.
            for (int i = 0; i + 1 < fill_count; i++) begin
                for (int j = i + 1; j < fill_count; j++) begin
                    if (store_key[i] < store_key[j]) begin
                        tk = store_key[i];
                        tt = store_tag[i];
                        store_key[i] = store_key[j];
                        store_tag[i] = store_tag[j];
                        store_key[j] = tk;
                        store_tag[j] = tt;
                    end
                end
            end
            for (int k = 0; k < fill_count; k++) begin
                w.key  = store_key[k];
                w.tag  = store_tag[k];
                w.rank = RANK_W'(k + 1);
                w.fin  = (k + 1 == fill_count);
                w.ovf  = lost_mark;
                ranked_q.push_back(w);
            end
            sets_sorted++;
            if (lost_mark) sets_overflowed++;
            fill_count = 0;
            lost_mark  = 1'b0;
        end
    endtask

    task automatic push_rec(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input logic last);
        t_rec_word r;
        r.key  = key;
        r.tag  = tag;
        r.last = last;
        pending_q.push_back(r);
        total_records++;
    endtask

    // Queue a whole set of n records with keys of the given style.
    task automatic add_set(input int n, input t_key_style style);
        logic [KEY_W-1:0] key;
        for (int k = 0; k < n; k++) begin
            case (style)
                KEYS_WIDE:   key = KEY_W'($urandom);
                KEYS_TIED:   key = KEY_W'($urandom_range(0, 3));
                KEYS_EDGES: begin
                    case ($urandom_range(0, 2))
                        0:       key = '0;
                        1:       key = '1;
                        default: key = KEY_W'($urandom);
                    endcase
                end
                default:     key = KEY_W'(k * 1000 + $urandom_range(0, 999));
            endcase
            push_rec(key, TAG_W'($urandom), k == n - 1);
        end
    endtask

    task automatic check_field(input string name, input logic [TAG_W-1:0] exp_v,
                               input logic [TAG_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Input driver: bursts of words with random gaps, a word held until it is taken.
    always @(negedge i_clk) begin
        if (!stim_go) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !offer_taken)) begin
            offer_taken = 1'b0;
            if (gap_left > 0 || pending_q.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                offer = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {offer.tag, offer.key};
                s_tlast  <= offer.last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Input monitor: every accepted word goes through the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            absorb_record(offer);
            offer_taken = 1'b1;
            accepted_count++;
        end
    end

    // Receiver: a stall pattern that changes mode now and then, plus the long hold.
    always @(negedge i_clk) begin
        logic rdy;
        if (rx_phase_left == 0) begin
            rx_mode       = t_rx_mode'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(16, 80);
        end
        rx_phase_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:  rdy = 1'b1;
            RX_COIN:  rdy = 1'($urandom_range(0, 1));
            RX_THIRD: rdy = (rx_tick % 3 == 0);
            default:  rdy = ($urandom_range(0, 4) == 0);
        endcase
        m_tready <= rdy && !rx_hold;
    end

    // Output monitor: compare each accepted word with the oldest expected one.
    always @(posedge i_clk) begin
        t_ranked_word w;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (ranked_q.size() == 0) begin
                $error("unexpected output word %h (tlast %b, tuser %b)", m_tdata, m_tlast,
                       m_tuser);
                fail_count++;
            end else begin
                w = ranked_q.pop_front();
                check_field("sorted_key", w.key, m_tdata[KEY_W-1:0]);
                check_field("sorted_tag", w.tag, m_tdata[KEY_W+TAG_W-1:KEY_W]);
                check_field("rank_position", w.rank,
                            m_tdata[KEY_W+TAG_W+RANK_W-1:KEY_W+TAG_W]);
                check_field("final_result", w.fin, m_tlast);
                check_field("overflow_flag", w.ovf, m_tuser);
                words_checked++;
            end
        end
    end

    // Long receiver hold while the sender keeps offering, so the block fills and stalls.
    initial begin
        wait (accepted_count >= 60);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int               pick;
        logic [KEY_W-1:0] step_key;

        // Single-record sets at both extremes of key and tag.
        push_rec('1, '1, 1'b1);
        push_rec('0, '0, 1'b1);
        // Tied keys around a maximum and a minimum.
        push_rec(16'd7, 32'h0000_0001, 1'b0);
        push_rec(16'd7, 32'h0000_0002, 1'b0);
        push_rec('1, 32'h0000_0003, 1'b0);
        push_rec('0, 32'h0000_0004, 1'b0);
        push_rec(16'd7, 32'h0000_0005, 1'b1);
        // Full store, then a last record that arrives with no room and is dropped.
        for (int k = 0; k < MAX_RECORDS; k++) begin
            step_key = KEY_W'(k * 4369);
            push_rec(step_key, TAG_W'(32'h1000_0000 + k), 1'b0);
        end
        push_rec('1, 32'h8000_0001, 1'b1);

        // Random sets: mostly well-formed, some exactly full, some overflowing.
        while (total_records < 170) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      pick = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
            else if (pick == 1) pick = MAX_RECORDS;
            else                pick = $urandom_range(1, MAX_RECORDS);
            add_set(pick, t_key_style'($urandom_range(0, 3)));
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        stim_go = 1'b1;

        wait (accepted_count == total_records);
        wait (ranked_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Loaded %0d records in %0d sets, %0d of them with dropped records.",
                 accepted_count, sets_sorted, sets_overflowed);
        $display("Checked %0d ranked words against the predicted order.", words_checked);
        if (fail_count == 0 && ranked_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
